// ----- hdl/gpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package gpp_pkg;

  localparam int MAX_AGENTS  = 64;
  localparam int AGENT_BITS  = 6;
  localparam int COUNT_BITS  = 7;
  localparam int VERTEX_BITS = 20;
  localparam int STEP_BITS   = 16;
  localparam int WIDTH_BITS  = 11;
  localparam int STAT_BITS   = 3;

  localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_GOAL  = 2'd1,
    CMD_LOC   = 2'd2,
    CMD_BEGIN = 2'd3
  } gpp_cmd_e;

  typedef enum logic [2:0] {
    K_START = 3'd0,
    K_GOAL  = 3'd1,
    K_LOC   = 3'd2,
    K_STEP  = 3'd3,
    K_BEGIN = 3'd4
  } gpp_kind_e;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK    = 3'd0,
    ST_START = 3'd1,
    ST_GOAL  = 3'd2,
    ST_MOVE  = 3'd3,
    ST_VERT  = 3'd4,
    ST_SWAP  = 3'd5
  } gpp_status_e;

  typedef struct packed {
    gpp_kind_e               kind;
    logic [AGENT_BITS-1:0]   agent;
    logic [VERTEX_BITS-1:0]  vertex;
    logic                    last;
  } gpp_entry_t;

  typedef struct packed {
    logic [STAT_BITS-1:0]   status;
    logic [STEP_BITS-1:0]   step_index;
    logic [AGENT_BITS-1:0]  first_agent;
    logic [AGENT_BITS-1:0]  second_agent;
    logic                   verdict_final;
  } gpp_result_t;

  localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_AGENTS);

  function automatic logic [COUNT_BITS-1:0] live_agents(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS-1:0] n;
    n = c;
    if (c == '0) n = COUNT_BITS'(1);
    else if (c > MAX_COUNT) n = MAX_COUNT;
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/gpp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gpp_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     cmd_i,
  input  wire logic [gpp_pkg::AGENT_BITS-1:0]  agent_i,
  input  wire logic [gpp_pkg::VERTEX_BITS-1:0] vertex_i,
  input  wire logic                           last_i,
  input  wire logic [gpp_pkg::COUNT_BITS-1:0]  n_i,
  output logic                                q_valid_o,
  output gpp_pkg::gpp_entry_t                 q_entry_o,
  input  wire logic                           q_pop_i
);
  import gpp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_BITS = 2;

  gpp_entry_t            fifo_q [DEPTH];
  logic [PTR_BITS-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PTR_BITS:0]     cnt_q, cnt_d;
  gpp_entry_t            ent;
  logic                  keep, push, pop;
  logic [COUNT_BITS-1:0] agent_ext;

  assign agent_ext  = {1'b0, agent_i};
  assign in_ready_o = (cnt_q != (PTR_BITS+1)'(DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_entry_o  = fifo_q[rd_q];

  // classify the request; locations of agents beyond the count are dropped
  always_comb begin
    ent.agent  = agent_i;
    ent.vertex = vertex_i;
    ent.last   = last_i;
    keep       = 1'b1;
    unique case (gpp_cmd_e'(cmd_i))
      CMD_START: ent.kind = K_START;
      CMD_GOAL:  ent.kind = K_GOAL;
      CMD_BEGIN: ent.kind = K_BEGIN;
      CMD_LOC: begin
        ent.kind = (agent_ext + COUNT_BITS'(1) == n_i) ? K_STEP : K_LOC;
        keep     = (agent_ext < n_i);
      end
      default: ent.kind = K_BEGIN;
    endcase
  end

  assign push  = in_valid_i && in_ready_o && keep;
  assign pop   = q_pop_i && q_valid_o;
  assign wr_d  = push ? wr_q + PTR_BITS'(1) : wr_q;
  assign rd_d  = pop ? rd_q + PTR_BITS'(1) : rd_q;
  assign cnt_d = cnt_q + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= ent;
  end

endmodule
`default_nettype wire

// ----- hdl/gpp_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gpp_mod (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [gpp_pkg::VERTEX_BITS-1:0] dividend_i,
  input  wire logic [gpp_pkg::WIDTH_BITS-1:0]  divisor_i,
  output logic                                busy_o,
  output logic [gpp_pkg::WIDTH_BITS-1:0]       rem_o
);
  import gpp_pkg::*;

  localparam int CNT_BITS = $clog2(VERTEX_BITS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(VERTEX_BITS - 1);

  logic                   busy_q;
  logic [CNT_BITS-1:0]    cnt_q;
  logic [VERTEX_BITS-1:0] dvd_q;
  logic [WIDTH_BITS-1:0]  dvs_q, rem_q;
  logic [WIDTH_BITS:0]    trial, diff;

  // restoring remainder, one dividend bit per cycle, msb first
  assign trial  = {rem_q, dvd_q[VERTEX_BITS-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign busy_o = busy_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_BITS'(1);
      if (cnt_q == LAST) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[VERTEX_BITS-2:0], 1'b0};
      rem_q <= (trial >= {1'b0, dvs_q}) ? diff[WIDTH_BITS-1:0] : trial[WIDTH_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gpp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gpp_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [gpp_pkg::COUNT_BITS-1:0] n_i,
  input  wire logic [gpp_pkg::WIDTH_BITS-1:0] w_i,
  input  wire logic                          q_valid_i,
  input  wire gpp_pkg::gpp_entry_t           q_entry_i,
  output logic                               q_pop_o,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output gpp_pkg::gpp_result_t               res_o
);
  import gpp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DISP   = 10'b00_0000_0010,
    S_START  = 10'b00_0000_0100,
    S_MV_RD  = 10'b00_0000_1000,
    S_MV_CHK = 10'b00_0001_0000,
    S_MV_MOD = 10'b00_0010_0000,
    S_PAIR   = 10'b00_0100_0000,
    S_GCHK   = 10'b00_1000_0000,
    S_GOAL   = 10'b01_0000_0000,
    S_EMIT   = 10'b10_0000_0000
  } state_e;

  logic [VERTEX_BITS-1:0] start_mem [MAX_AGENTS];
  logic [VERTEX_BITS-1:0] goal_mem  [MAX_AGENTS];
  logic [VERTEX_BITS-1:0] cur_mem   [MAX_AGENTS];
  logic [VERTEX_BITS-1:0] prev_mem  [MAX_AGENTS];
  logic [VERTEX_BITS-1:0] start_rd_q, goal_rd_q, cur_rd_q, prev_rd_q;

  state_e                 state_q, state_d;
  logic                   copy_q, copy_d;
  logic [COUNT_BITS-1:0]  idx_q, idx_d;
  logic                   chk_v_q, chk_v_d;
  logic [AGENT_BITS-1:0]  chk_i_q, chk_i_d, i_q, i_d;
  logic [VERTEX_BITS-1:0] fi_q, fi_d, ti_q, ti_d;
  logic                   last_q, last_d;
  logic [STAT_BITS-1:0]   st_q, st_d;
  logic [AGENT_BITS-1:0]  a1_q, a1_d, a2_q, a2_d;
  logic [STEP_BITS-1:0]   t_q, t_d;
  logic                   out_v_q, out_v_d;
  gpp_result_t            out_q, out_d;

  logic [AGENT_BITS-1:0]  rd_addr;
  logic                   issue, cur_we, start_we, goal_we, prev_we;
  logic                   mod_start, mod_busy;
  logic [WIDTH_BITS-1:0]  mod_rem;
  logic [VERTEX_BITS-1:0] mod_lo;
  logic [VERTEX_BITS:0]   fi_w, ti_w, fi_1, ti_1, fi_x, ti_x;
  logic [COUNT_BITS-1:0]  i_next;

  gpp_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_lo),
    .divisor_i  (w_i),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  assign issue   = (idx_q < n_i);
  assign rd_addr = (state_q == S_MV_RD) ? i_q : idx_q[AGENT_BITS-1:0];
  assign i_next  = {1'b0, i_q} + COUNT_BITS'(1);
  assign fi_x    = {1'b0, prev_rd_q};
  assign ti_x    = {1'b0, cur_rd_q};
  assign fi_w    = fi_x + {{(VERTEX_BITS-WIDTH_BITS+1){1'b0}}, w_i};
  assign ti_w    = ti_x + {{(VERTEX_BITS-WIDTH_BITS+1){1'b0}}, w_i};
  assign fi_1    = fi_x + (VERTEX_BITS+1)'(1);
  assign ti_1    = ti_x + (VERTEX_BITS+1)'(1);

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  always_comb begin
    state_d   = state_q;
    copy_d    = copy_q;
    idx_d     = idx_q;
    chk_v_d   = chk_v_q;
    chk_i_d   = chk_i_q;
    i_d       = i_q;
    fi_d      = fi_q;
    ti_d      = ti_q;
    last_d    = last_q;
    st_d      = st_q;
    a1_d      = a1_q;
    a2_d      = a2_q;
    t_d       = t_q;
    out_d     = out_q;
    out_v_d   = out_v_q && !res_ready_i;
    q_pop_o   = 1'b0;
    cur_we    = 1'b0;
    start_we  = 1'b0;
    goal_we   = 1'b0;
    prev_we   = 1'b0;
    mod_start = 1'b0;
    mod_lo    = (fi_1 == ti_x) ? prev_rd_q : cur_rd_q;

    // cur to prev sweep, pipelined over the registered read
    if (copy_q) begin
      prev_we = chk_v_q;
      chk_v_d = issue;
      chk_i_d = idx_q[AGENT_BITS-1:0];
      if (issue) idx_d = idx_q + COUNT_BITS'(1);
      if (!issue && !chk_v_q) begin
        copy_d = 1'b0;
        if (t_q != STEP_MAX) t_d = t_q + STEP_BITS'(1);
        if (last_q) begin
          t_d  = '0;
          st_d = ST_OK;
          a1_d = '0;
          a2_d = '0;
        end
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            q_pop_o = 1'b1;
            unique case (q_entry_i.kind)
              K_START: start_we = 1'b1;
              K_GOAL:  goal_we  = 1'b1;
              K_LOC:   cur_we   = 1'b1;
              K_STEP: begin
                cur_we  = 1'b1;
                last_d  = q_entry_i.last;
                state_d = S_DISP;
              end
              K_BEGIN: begin
                t_d  = '0;
                st_d = ST_OK;
                a1_d = '0;
                a2_d = '0;
              end
              default: ;
            endcase
          end
        end
        S_DISP: begin
          idx_d   = '0;
          chk_v_d = 1'b0;
          i_d     = '0;
          if (st_q != ST_OK) state_d = S_GCHK;
          else if (t_q == '0) state_d = S_START;
          else state_d = S_MV_RD;
        end
        S_START, S_GOAL: begin
          if (chk_v_q && (cur_rd_q != ((state_q == S_START) ? start_rd_q : goal_rd_q))) begin
            st_d    = (state_q == S_START) ? ST_START : ST_GOAL;
            a1_d    = chk_i_q;
            a2_d    = '0;
            state_d = (state_q == S_START) ? S_GCHK : S_EMIT;
          end else begin
            chk_v_d = issue;
            chk_i_d = idx_q[AGENT_BITS-1:0];
            if (issue) idx_d = idx_q + COUNT_BITS'(1);
            if (!issue && !chk_v_q) state_d = (state_q == S_START) ? S_GCHK : S_EMIT;
          end
        end
        S_MV_RD: state_d = S_MV_CHK;
        S_MV_CHK: begin
          fi_d    = prev_rd_q;
          ti_d    = cur_rd_q;
          idx_d   = i_next;
          chk_v_d = 1'b0;
          if (prev_rd_q == cur_rd_q || fi_w == ti_x || ti_w == fi_x) begin
            state_d = S_PAIR;
          end else if (fi_1 == ti_x || ti_1 == fi_x) begin
            mod_start = 1'b1;
            state_d   = S_MV_MOD;
          end else begin
            st_d    = ST_MOVE;
            a1_d    = i_q;
            a2_d    = '0;
            state_d = S_GCHK;
          end
        end
        S_MV_MOD: begin
          // a step right from the last column wraps to the next row
          if (!mod_busy) begin
            if (mod_rem == w_i - WIDTH_BITS'(1)) begin
              st_d    = ST_MOVE;
              a1_d    = i_q;
              a2_d    = '0;
              state_d = S_GCHK;
            end else begin
              state_d = S_PAIR;
            end
          end
        end
        S_PAIR: begin
          if (chk_v_q && cur_rd_q == ti_q) begin
            st_d    = ST_VERT;
            a1_d    = i_q;
            a2_d    = chk_i_q;
            state_d = S_GCHK;
          end else if (chk_v_q && cur_rd_q == fi_q && prev_rd_q == ti_q) begin
            st_d    = ST_SWAP;
            a1_d    = i_q;
            a2_d    = chk_i_q;
            state_d = S_GCHK;
          end else begin
            chk_v_d = issue;
            chk_i_d = idx_q[AGENT_BITS-1:0];
            if (issue) idx_d = idx_q + COUNT_BITS'(1);
            if (!issue && !chk_v_q) begin
              if (i_next == n_i) state_d = S_GCHK;
              else begin
                i_d     = i_next[AGENT_BITS-1:0];
                state_d = S_MV_RD;
              end
            end
          end
        end
        S_GCHK: begin
          idx_d   = '0;
          chk_v_d = 1'b0;
          state_d = (last_q && st_q != ST_START) ? S_GOAL : S_EMIT;
        end
        S_EMIT: begin
          if (!out_v_q || res_ready_i) begin
            out_v_d             = 1'b1;
            out_d.status        = st_q;
            out_d.step_index    = t_q;
            out_d.first_agent   = a1_q;
            out_d.second_agent  = a2_q;
            out_d.verdict_final = last_q;
            idx_d               = '0;
            chk_v_d             = 1'b0;
            copy_d              = 1'b1;
            state_d             = S_IDLE;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      copy_q  <= 1'b0;
      idx_q   <= '0;
      chk_v_q <= 1'b0;
      i_q     <= '0;
      last_q  <= 1'b0;
      st_q    <= ST_OK;
      a1_q    <= '0;
      a2_q    <= '0;
      t_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      copy_q  <= copy_d;
      idx_q   <= idx_d;
      chk_v_q <= chk_v_d;
      i_q     <= i_d;
      last_q  <= last_d;
      st_q    <= st_d;
      a1_q    <= a1_d;
      a2_q    <= a2_d;
      t_q     <= t_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_i_q <= chk_i_d;
    fi_q    <= fi_d;
    ti_q    <= ti_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (start_we) start_mem[q_entry_i.agent] <= q_entry_i.vertex;
    start_rd_q <= start_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (goal_we) goal_mem[q_entry_i.agent] <= q_entry_i.vertex;
    goal_rd_q <= goal_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[q_entry_i.agent] <= q_entry_i.vertex;
    cur_rd_q <= cur_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[chk_i_q] <= cur_rd_q;
    prev_rd_q <= prev_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- hdl/grid_path_plan_feasibility_check_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// multi-agent grid plan checker
// s_* channel carries requests: tuser is the command (load start, load goal,
// plan location, begin plan), tdata the agent and vertex, tlast marks a
// location of the plan's last timestep. locations come in agent order; the
// request for agent count-1 closes a timestep and yields one result on m_*.
// m_* tdata holds status, step index and the two agents; tlast is set on the
// plan's final verdict. load, begin and non-closing location requests pass
// through a 4-entry request queue and give no result. a closing request
// runs the start check at step 0, else per agent i a read, a move check
// (plus the serial remainder unit when the move is one index apart) and a
// pairwise scan of n-1-i agents; these checks are skipped once an error is
// held. on the last step the goal check follows unless a start error is
// held; then current locations are rolled into the previous table.
// configuration: cfg_idx_i 0 agent count, 1 grid width; write only when idle.
// reset clears queue, counters and sticky error; location tables are not
// cleared. a stalled receiver holds one result in the output register while
// the queue keeps taking requests; the back end waits only at its next result.
module grid_path_plan_feasibility_check_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [10:0] cfg_data_i,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [31:0] s_tdata_i,   // agent [5:0], vertex [25:6], zero fill
  input  wire logic [1:0]  s_tuser_i,   // cmd [1:0]
  input  wire logic        s_tlast_i,   // final_step
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [31:0]      m_tdata_o,   // status [2:0], step_index [18:3],
                                        // first_agent [24:19], second_agent [30:25]
  output logic             m_tlast_o    // verdict_final
);
  import gpp_pkg::*;

  localparam logic CFG_COUNT = 1'b0;
  localparam logic CFG_WIDTH = 1'b1;

  logic [COUNT_BITS-1:0] count_q;
  logic [WIDTH_BITS-1:0] width_q;
  logic [COUNT_BITS-1:0] n_eff;
  logic [WIDTH_BITS-1:0] w_eff;
  logic                  q_valid, q_pop;
  gpp_entry_t            q_entry;
  gpp_result_t           res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_BITS'(1);
      width_q <= WIDTH_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COUNT: count_q <= cfg_data_i[COUNT_BITS-1:0];
        CFG_WIDTH: width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero count acts as one agent and counts above 64 as 64, zero width as one column
  assign n_eff = live_agents(count_q);
  assign w_eff = (width_q == '0) ? WIDTH_BITS'(1) : width_q;

  gpp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .cmd_i      (s_tuser_i),
    .agent_i    (s_tdata_i[AGENT_BITS-1:0]),
    .vertex_i   (s_tdata_i[AGENT_BITS+VERTEX_BITS-1:AGENT_BITS]),
    .last_i     (s_tlast_i),
    .n_i        (n_eff),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  gpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .w_i         (w_eff),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .res_valid_o (m_tvalid_o),
    .res_ready_i (m_tready_i),
    .res_o       (res)
  );

  // pack result fields, lowest first
  assign m_tdata_o = {1'b0, res.second_agent, res.first_agent, res.step_index, res.status};
  assign m_tlast_o = res.verdict_final;

endmodule
`default_nettype wire

// ----- verif/gpp_plan_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gpp_plan_checker
  import gpp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [10:0] cfg_data_i,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [31:0] s_tdata_i,
  input  wire logic [1:0]  s_tuser_i,
  input  wire logic        s_tlast_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [31:0] m_tdata_i,
  input  wire logic        m_tlast_i,
  output int               fail_count_o,
  output int               pending_o
);

  logic [VERTEX_BITS-1:0] start_vtx [MAX_AGENTS];
  logic [VERTEX_BITS-1:0] goal_vtx  [MAX_AGENTS];
  logic [VERTEX_BITS-1:0] prev_vtx  [MAX_AGENTS];
  logic [VERTEX_BITS-1:0] cur_vtx   [MAX_AGENTS];
  logic [STEP_BITS-1:0]   step_cnt;
  gpp_status_e            err_status;
  logic [AGENT_BITS-1:0]  err_first, err_second;
  logic [COUNT_BITS-1:0]  count_reg;
  logic [WIDTH_BITS-1:0]  width_reg;
  gpp_result_t            verdicts_q [$];

  function automatic bit one_cell_apart(int unsigned a, int unsigned b, int unsigned w);
    int unsigned ra, ca, rb, cb, dr, dc;
    ra = a / w; ca = a % w; rb = b / w; cb = b % w;
    dr = (ra > rb) ? ra - rb : rb - ra;
    dc = (ca > cb) ? ca - cb : cb - ca;
    return (dr == 1 && dc == 0) || (dr == 0 && dc == 1);
  endfunction

  // first move or conflict error in agent order, OK if none
  function automatic gpp_status_e scan_step(int unsigned n, int unsigned w,
                                            output int a1, output int a2);
    a1 = 0; a2 = 0;
    for (int i = 0; i < n; i++) begin
      if (cur_vtx[i] != prev_vtx[i] && !one_cell_apart(prev_vtx[i], cur_vtx[i], w)) begin
        a1 = i;
        a2 = 0;
        return ST_MOVE;
      end
      for (int j = i + 1; j < n; j++) begin
        a1 = i; a2 = j;
        if (cur_vtx[j] == cur_vtx[i]) return ST_VERT;
        if (cur_vtx[j] == prev_vtx[i] && prev_vtx[j] == cur_vtx[i]) return ST_SWAP;
      end
    end
    a1 = 0; a2 = 0;
    return ST_OK;
  endfunction

  function automatic void clear_plan();
    step_cnt = '0;
    err_status = ST_OK;
    err_first = '0;
    err_second = '0;
  endfunction

  function automatic void track_request(gpp_cmd_e c, int unsigned ag,
                                        logic [VERTEX_BITS-1:0] v, logic fin);
    int unsigned n, w;
    int a1, a2;
    gpp_status_e st;
    gpp_result_t r;
    n = (count_reg == 0) ? 1 : (count_reg > MAX_AGENTS) ? MAX_AGENTS : count_reg;
    w = (width_reg == 0) ? 1 : width_reg;
    case (c)
      CMD_BEGIN: clear_plan();
      CMD_START: start_vtx[ag] = v;
      CMD_GOAL:  goal_vtx[ag] = v;
      default: begin
        if (ag >= n) return;
        cur_vtx[ag] = v;
        if (ag != n - 1) return;
        if (step_cnt == 0) begin
          if (err_status == ST_OK)
            for (int i = 0; i < n; i++)
              if (cur_vtx[i] != start_vtx[i]) begin
                err_status = ST_START; err_first = AGENT_BITS'(i); err_second = '0;
                break;
              end
        end else if (err_status == ST_OK) begin
          st = scan_step(n, w, a1, a2);
          if (st != ST_OK) begin
            err_status = st; err_first = AGENT_BITS'(a1); err_second = AGENT_BITS'(a2);
          end
        end
        // goal check outranks step errors but not a start error
        if (fin && err_status != ST_START)
          for (int i = 0; i < n; i++)
            if (cur_vtx[i] != goal_vtx[i]) begin
              err_status = ST_GOAL; err_first = AGENT_BITS'(i); err_second = '0;
              break;
            end
        r.status = err_status;
        r.step_index = step_cnt;
        r.first_agent = err_first;
        r.second_agent = err_second;
        r.verdict_final = fin;
        verdicts_q.insert(verdicts_q.size(), r);
        for (int i = 0; i < n; i++) prev_vtx[i] = cur_vtx[i];
        if (step_cnt != STEP_MAX) step_cnt++;
        if (fin) clear_plan();
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gpp_result_t e;
    if (!rst_ni) begin
      verdicts_q.delete();
      clear_plan();
      count_reg = 7'd1;
      width_reg = 11'd1;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == 1'b0) count_reg = cfg_data_i[COUNT_BITS-1:0];
        else width_reg = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i)
        track_request(gpp_cmd_e'(s_tuser_i), s_tdata_i[5:0], s_tdata_i[25:6], s_tlast_i);
      if (m_tvalid_i && m_tready_i) begin
        if (verdicts_q.size() == 0) begin
          $error("result with no expectation: tdata %h tlast %b", m_tdata_i, m_tlast_i);
          fail_count_o++;
        end else begin
          e = verdicts_q.pop_front();
          check_field("status", e.status, m_tdata_i[2:0]);
          check_field("step_index", e.step_index, m_tdata_i[18:3]);
          check_field("first_agent", e.first_agent, m_tdata_i[24:19]);
          check_field("second_agent", e.second_agent, m_tdata_i[30:25]);
          check_field("verdict_final", e.verdict_final, m_tlast_i);
        end
      end
      pending_o = verdicts_q.size();
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_grid_path_plan_feasibility_check_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_grid_path_plan_feasibility_check_core;
  import gpp_pkg::*;

  // configuration register indexes
  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_WIDTH = 1'b1;
  localparam int   TARGET_REQS = 1100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [10:0] cfg_data_i = '0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [31:0] s_tdata_i = '0;   // agent [5:0], vertex [25:6], zero fill
  logic [1:0]  s_tuser_i = '0;   // cmd [1:0]
  logic        s_tlast_i = 1'b0; // final_step
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [31:0] m_tdata_o;        // status [2:0], step_index [18:3],
                                 // first_agent [24:19], second_agent [30:25]
  logic        m_tlast_o;        // verdict_final

  int fail_count, pending;

  // generator view of the plan
  int unsigned            n_live, w_live, sent;
  int unsigned            burst_left;
  logic [VERTEX_BITS-1:0] at_vtx [MAX_AGENTS];
  logic [VERTEX_BITS-1:0] home_vtx [MAX_AGENTS];
  logic                   long_stall_kick = 1'b0;

  grid_path_plan_feasibility_check_core u_dut (.*);

  gpp_plan_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_tvalid_i, .s_tready_i(s_tready_o), .s_tdata_i, .s_tuser_i, .s_tlast_i,
    .m_tvalid_i(m_tvalid_o), .m_tready_i, .m_tdata_i(m_tdata_o), .m_tlast_i(m_tlast_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial forever #2 clk_i = ~clk_i;

  // receiver: ready phases run always-ready, random and mostly-stalled, plus one long hold-off
  int  hold_left = 0;
  bit  long_stall_done = 0;
  int unsigned ready_tick = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready_i <= 1'b0;
    end else if (long_stall_kick && !long_stall_done) begin
      // queue fills behind the held result and stalls the sender
      long_stall_done = 1;
      hold_left = 3000;
      m_tready_i <= 1'b0;
    end else begin
      ready_tick++;
      case (ready_tick[8:6])
        3'd0, 3'd1, 3'd2: m_tready_i <= 1'b1;
        3'd3, 3'd4, 3'd5: m_tready_i <= $urandom_range(0, 1);
        default:          m_tready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // one request, in bursts with random gaps between them
  task automatic push(gpp_cmd_e c, int unsigned ag, logic [VERTEX_BITS-1:0] v, logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i <= c;
    s_tdata_i <= {6'd0, v, 6'(ag)};
    s_tlast_i <= fin;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    burst_left--;
    sent++;
    if (sent == 300) long_stall_kick <= 1'b1;
  endtask

  // waits out all results plus the back end's table roll, then writes a register
  task automatic set_reg(logic idx, logic [10:0] val);
    s_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [10:0] cnt, logic [10:0] wid);
    set_reg(REG_COUNT, cnt);
    set_reg(REG_WIDTH, wid);
    n_live = (cnt == 0) ? 1 : (cnt > MAX_AGENTS) ? MAX_AGENTS : cnt;
    w_live = (wid == 0) ? 1 : wid;
  endtask

  // one timestep in agent order; agent n-1 always closes it
  task automatic send_step(logic fin, bit first);
    for (int i = 0; i < n_live; i++) begin
      if (!first && i != n_live - 1 && $urandom_range(0, 19) == 0) continue;  // missing
      push(CMD_LOC, i, at_vtx[i], fin);
      // ignored location of an agent beyond the count
      if (n_live < MAX_AGENTS && $urandom_range(0, 29) == 0)
        push(CMD_LOC, $urandom_range(n_live, MAX_AGENTS - 1), 20'($urandom), fin);
    end
  endtask

  task automatic move_agents();
    for (int i = 0; i < n_live; i++)
      case ($urandom_range(0, 19))
        6, 7, 8:     at_vtx[i] = at_vtx[i] + 20'd1;
        9, 10, 11:   at_vtx[i] = at_vtx[i] - 20'd1;
        12, 13, 14:  at_vtx[i] = at_vtx[i] + 20'(w_live);
        15, 16, 17:  at_vtx[i] = at_vtx[i] - 20'(w_live);
        18:          at_vtx[i] = 20'($urandom);   // teleport, bad move
        default: ;                                // wait in place
      endcase
  endtask

  task automatic run_plan(int unsigned steps);
    if ($urandom_range(0, 1))
      push(CMD_BEGIN, $urandom_range(0, 63), 20'($urandom), 1'($urandom));
    for (int i = 0; i < n_live; i++) at_vtx[i] = home_vtx[i];
    if ($urandom_range(0, 9) == 0) at_vtx[$urandom_range(0, n_live - 1)] = 20'($urandom);
    send_step(steps == 1, 1);
    for (int s = 1; s < steps; s++) begin
      move_agents();
      if (s == steps - 1 && $urandom_range(0, 1))
        for (int i = 0; i < n_live; i++) push(CMD_GOAL, i, at_vtx[i], 1'($urandom));
      // rare restart in the middle of a plan
      if ($urandom_range(0, 39) == 0) push(CMD_BEGIN, 0, 0, 1'b0);
      send_step(s == steps - 1, 0);
    end
  endtask

  task automatic load_homes(logic [VERTEX_BITS-1:0] base);
    for (int i = 0; i < n_live; i++) begin
      home_vtx[i] = base + 20'(2 * i);
      push(CMD_START, i, home_vtx[i], 1'($urandom));
      push(CMD_GOAL, i, 20'($urandom), 1'($urandom));
    end
  endtask

  logic [10:0] cnt_set [8] = '{11'd3, 11'd2, 11'd0, 11'd5, 11'd100, 11'd8, 11'd1, 11'd64};
  logic [10:0] wid_set [8] = '{11'd4, 11'd1, 11'd0, 11'd1024, 11'd7, 11'd2047, 11'd3, 11'd1};

  initial begin
    int unsigned k;
    sent = 0;
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // setup: every start and goal entry written once
    n_live = MAX_AGENTS;
    load_homes(20'd0);
    set_config(11'd1, 11'd1);

    // single agent: clean step, goal miss, start miss on a final step, bad move
    push(CMD_LOC, 0, 20'd0, 1'b0);
    push(CMD_LOC, 0, 20'd1, 1'b1);
    push(CMD_GOAL, 0, 20'hFFFFF, 1'b0);
    push(CMD_LOC, 0, 20'hFFFFF, 1'b1);
    push(CMD_BEGIN, 0, 20'd0, 1'b0);
    push(CMD_LOC, 0, 20'd0, 1'b0);
    push(CMD_LOC, 0, 20'd2, 1'b0);
    push(CMD_LOC, 0, 20'd3, 1'b0);
    push(CMD_LOC, 5, 20'd9, 1'b0);       // beyond count, ignored
    push(CMD_BEGIN, 63, 20'hFFFFF, 1'b1);
    push(CMD_LOC, 0, 20'd0, 1'b0);
    push(CMD_LOC, 0, 20'd1, 1'b1);       // goal miss after valid move

    // two agents on a 3-wide grid: swap, then vertex conflict
    set_config(11'd2, 11'd3);
    push(CMD_START, 1, 20'd1, 1'b0);
    push(CMD_GOAL, 0, 20'd1, 1'b0);
    push(CMD_GOAL, 1, 20'd0, 1'b0);
    push(CMD_LOC, 0, 20'd0, 1'b0);
    push(CMD_LOC, 1, 20'd1, 1'b0);
    push(CMD_LOC, 0, 20'd1, 1'b1);
    push(CMD_LOC, 1, 20'd0, 1'b1);
    push(CMD_LOC, 0, 20'd0, 1'b0);
    push(CMD_LOC, 1, 20'd1, 1'b0);
    push(CMD_LOC, 0, 20'd1, 1'b1);
    push(CMD_LOC, 1, 20'd1, 1'b1);

    // random phases across settings, wide agent counts kept short
    k = 0;
    while (sent < TARGET_REQS) begin
      set_config(cnt_set[k % 8], wid_set[k % 8]);
      load_homes((k % 3 == 0) ? 20'hFFF80 : 20'($urandom_range(0, 20'hFFF00)));
      if (n_live >= 32) run_plan($urandom_range(1, 3));
      else repeat (4) run_plan($urandom_range(1, 8));
      k++;
    end

    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("PASS grid_path_plan_feasibility_check_core");
    else $display("FAIL grid_path_plan_feasibility_check_core");
    $finish;
  end

  initial begin
    #4ms;
    $display("FAIL grid_path_plan_feasibility_check_core");
    $finish;
  end

endmodule
`default_nettype wire
